@@ hw/rtl/usbs_pkg.sv @@
// ----------------------------------------------------------------------------
// usbs_pkg
// Shared types and constants for the UTF-8 byte sanitizer.
// ----------------------------------------------------------------------------
package usbs_pkg;

	localparam logic [7:0] QMARK      = 8'h3F;
	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] CODE_LEAD2 = 8'hC0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] CODE_LEAD3 = 8'hE0;
	localparam logic [7:0] MASK_LEAD4 = 8'hF8;
	localparam logic [7:0] CODE_LEAD4 = 8'hF0;
	localparam logic [7:0] MASK_CONT  = 8'hC0;
	localparam logic [7:0] CODE_CONT  = 8'h80;

	localparam int MAX_RES = 4;
	localparam int HELD_DEPTH = 3;

	// Results caused by one input byte.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [MAX_RES-1:0]      sub;
		logic [2:0]              count;
		logic                    last;
	} res_grp_t;

	// Sequence tracking state update.
	typedef struct packed {
		logic [2:0] exp_len;
		logic [1:0] held_cnt;
		logic       wr_en;
		logic [1:0] wr_idx;
	} seq_upd_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		if ((b & MASK_LEAD2) == CODE_LEAD2) return 3'd2;
		if ((b & MASK_LEAD3) == CODE_LEAD3) return 3'd3;
		if ((b & MASK_LEAD4) == CODE_LEAD4) return 3'd4;
		return 3'd0;
	endfunction

endpackage

@@ hw/rtl/utf8_byte_sanitizer_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_unit
// Streaming UTF-8 check: passes well-formed sequences, replaces bad bytes by '?'.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one raw byte per transfer, in_last
//    on the final byte of a string.
//  - Output channel (out_valid / out_stall): zero to four bytes per input
//    byte. out_run_last flags the last byte caused by an input byte,
//    out_string_end the final byte of a string, out_substituted a '?'.
//  - Path: an input transfer is captured in the input register, decoded from
//    there into the result group register once that register is free, and
//    its first output byte is offered from the result group register.
//  - Throughput: one input byte per cycle while each byte gives at most one
//    result and out_stall stays low; an input byte giving several results
//    holds the input until the single output port has drained the group.
//  - Multi-byte sequences are held (no output) until complete; a sequence
//    cut by a non-continuation byte or by in_last turns into one '?' per
//    held byte.
//  - Reset (arst_n low) empties both registers and drops any pending
//    sequence.
//  - When out_stall is high the current output byte holds; the input
//    register keeps its byte, if any, and in_stall rises until the group drains.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer_unit import usbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_substituted,
	output logic       out_run_last,
	output logic       out_string_end
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// pending sequence state
	logic [HELD_DEPTH-1:0][7:0] held_q;
	logic [2:0]                 exp_len_q;
	logic [1:0]                 held_cnt_q;

	res_grp_t grp;
	seq_upd_t upd;
	logic     free;
	logic     adv;
	logic     in_xfer;

	// s1 moves on as soon as the result group register is (or becomes) free
	assign adv      = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	usbs_decode u_decode (
		.in_byte  (byte_s1),
		.in_last  (last_s1),
		.held     (held_q),
		.exp_len  (exp_len_q),
		.held_cnt (held_cnt_q),
		.grp      (grp),
		.upd      (upd)
	);

	// sequence state commits together with the result group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q  <= 3'd0;
			held_cnt_q <= 2'd0;
		end else if (adv) begin
			exp_len_q  <= upd.exp_len;
			held_cnt_q <= upd.held_cnt;
		end
	end

	// held bytes: only entries written since the last flush are read
	always_ff @(posedge clk) begin
		if (adv && upd.wr_en) held_q[upd.wr_idx] <= byte_s1;
	end

	usbs_out_buf u_out_buf (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (adv),
		.grp             (grp),
		.free            (free),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.out_substituted (out_substituted),
		.out_run_last    (out_run_last),
		.out_string_end  (out_string_end)
	);

endmodule

@@ hw/rtl/usbs_decode.sv @@
// ----------------------------------------------------------------------------
// usbs_decode
// Classifies one byte against the pending sequence; builds its result group.
// ----------------------------------------------------------------------------
module usbs_decode import usbs_pkg::*; (
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	input  logic [HELD_DEPTH-1:0][7:0]  held,
	input  logic [2:0]                  exp_len,
	input  logic [1:0]                  held_cnt,
	output res_grp_t                    grp,
	output seq_upd_t                    upd
);

	logic       pend;
	logic       is_cont;
	logic       complete;
	logic       do_fresh;
	logic [2:0] base;
	logic [2:0] len;

	assign pend     = exp_len != 3'd0;
	assign is_cont  = (in_byte & MASK_CONT) == CODE_CONT;
	assign complete = ({1'b0, held_cnt} + 3'd1) >= exp_len;
	assign len      = lead_length(in_byte);

	always_comb begin
		grp          = '0;
		grp.last     = in_last;
		upd.exp_len  = exp_len;
		upd.held_cnt = held_cnt;
		upd.wr_en    = 1'b0;
		upd.wr_idx   = held_cnt;
		do_fresh     = 1'b0;
		base         = 3'd0;

		if (pend && !is_cont) begin
			// broken sequence: one mark per held byte, then start over
			for (int j = 0; j < HELD_DEPTH; j++) begin
				if (j < int'(held_cnt)) begin
					grp.bytes[j] = QMARK;
					grp.sub[j]   = 1'b1;
				end
			end
			base         = {1'b0, held_cnt};
			grp.count    = {1'b0, held_cnt};
			upd.exp_len  = 3'd0;
			upd.held_cnt = 2'd0;
			do_fresh     = 1'b1;
		end else if (pend && complete) begin
			for (int j = 0; j < HELD_DEPTH; j++) begin
				if (j < int'(held_cnt)) grp.bytes[j] = held[j];
			end
			grp.bytes[held_cnt] = in_byte;
			grp.count           = {1'b0, held_cnt} + 3'd1;
			upd.exp_len         = 3'd0;
			upd.held_cnt        = 2'd0;
		end else if (pend) begin
			upd.wr_en    = 1'b1;
			upd.held_cnt = held_cnt + 2'd1;
			if (in_last) begin
				// cut off: mark every held byte including this one
				for (int j = 0; j < MAX_RES; j++) begin
					if (j <= int'(held_cnt)) begin
						grp.bytes[j] = QMARK;
						grp.sub[j]   = 1'b1;
					end
				end
				grp.count    = {1'b0, held_cnt} + 3'd1;
				upd.exp_len  = 3'd0;
				upd.held_cnt = 2'd0;
			end
		end else begin
			do_fresh = 1'b1;
		end

		if (do_fresh) begin
			if (in_byte <= ASCII_MAX) begin
				grp.bytes[base[1:0]] = in_byte;
				grp.count            = base + 3'd1;
			end else if (len != 3'd0) begin
				upd.wr_en  = 1'b1;
				upd.wr_idx = 2'd0;
				if (in_last) begin
					grp.bytes[base[1:0]] = QMARK;
					grp.sub[base[1:0]]   = 1'b1;
					grp.count            = base + 3'd1;
					upd.exp_len          = 3'd0;
					upd.held_cnt         = 2'd0;
				end else begin
					upd.exp_len  = len;
					upd.held_cnt = 2'd1;
				end
			end else begin
				grp.bytes[base[1:0]] = QMARK;
				grp.sub[base[1:0]]   = 1'b1;
				grp.count            = base + 3'd1;
			end
		end
	end

endmodule

@@ hw/rtl/usbs_out_buf.sv @@
// ----------------------------------------------------------------------------
// usbs_out_buf
// Result group register; hands out its bytes one transfer per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module usbs_out_buf import usbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_grp_t   grp,
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_substituted,
	output logic       out_run_last,
	output logic       out_string_end
);

	res_grp_t   grp_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       take;

	assign out_valid       = valid_s2;
	assign take            = valid_s2 && !out_stall;
	assign out_byte        = grp_s2.bytes[idx_q];
	assign out_substituted = grp_s2.sub[idx_q];
	assign out_run_last    = {1'b0, idx_q} == (grp_s2.count - 3'd1);
	assign out_string_end  = out_run_last && grp_s2.last;
	assign free            = !valid_s2 || (take && out_run_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= grp.count != 3'd0;
			idx_q    <= 2'd0;
		end else if (take) begin
			if (out_run_last) begin
				valid_s2 <= 1'b0;
				idx_q    <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) grp_s2 <= grp;
	end

endmodule

@@ sim/tb_utf8_byte_sanitizer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_sanitizer_unit
// Self-checking bench for the UTF-8 byte sanitizer. Byte strings go in through
// the valid/stall input channel, and a behavioral model of the sanitizer
// predicts every output byte with its flags. The output checker compares each
// transfer against the oldest prediction. Traffic runs under several idle and
// stall mixes, plus one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_utf8_byte_sanitizer_unit import usbs_pkg::*;;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;
	localparam int DRAIN_WAIT  = 12;

	// One predicted output transfer
	typedef struct packed {
		logic [7:0] data;
		logic       sub;
		logic       run_last;
		logic       str_end;
	} clean_byte_t;

	logic       clk             = 1'b0;
	logic       arst_n          = 1'b0;
	logic       in_valid        = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte         = 8'h00;
	logic       in_last         = 1'b0;
	logic       out_valid;
	logic       out_stall       = 1'b0;
	logic [7:0] out_byte;
	logic       out_substituted;
	logic       out_run_last;
	logic       out_string_end;

	// Idle mix, percent of cycles
	int send_idle_pct = 0;
	int stall_pct     = 0;

	// Long output hold: requested by a test, counted down by the stall process
	int hold_req  = 0;
	int hold_left = 0;

	int mismatch_cnt = 0;
	int cycle_cnt    = 0;

	// Model state: pending multi-byte sequence
	logic [7:0] seq_held [HELD_DEPTH];
	logic [2:0] seq_need = 3'd0;
	logic [1:0] seq_have = 2'd0;

	// Bytes produced by the input byte being modeled
	logic [7:0] step_data [$];
	logic       step_sub [$];

	// Predicted output transfers, oldest first
	clean_byte_t clean_q [$];

	utf8_byte_sanitizer_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_byte         (in_byte),
		.in_last         (in_last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.out_substituted (out_substituted),
		.out_run_last    (out_run_last),
		.out_string_end  (out_string_end)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transfers still expected",
				cycle_cnt, clean_q.size());
			$display("tb_utf8_byte_sanitizer_unit: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sanitizer model
	// ------------------------------------------------------------------------

	// Sequence length announced by a lead byte, 0 if not a lead
	function automatic int utf8_seq_len(input logic [7:0] b);
		casez (b)
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	function automatic void add_step_byte(input logic [7:0] b, input logic sub);
		step_data.insert(step_data.size(), b);
		step_sub.insert(step_sub.size(), sub);
	endfunction

	// Every held byte turns into a '?', and the sequence is dropped
	function automatic void flush_held_marks();
		for (int k = 0; k < int'(seq_have); k++)
			add_step_byte(QMARK, 1'b1);
		seq_need = 3'd0;
		seq_have = 2'd0;
	endfunction

	// Byte handled with nothing pending
	function automatic void take_fresh(input logic [7:0] b, input logic last);
		int len;
		len = utf8_seq_len(b);
		if (b <= ASCII_MAX) begin
			add_step_byte(b, 1'b0);
		end else if (len == 0) begin
			// stray continuation or 0xF8..0xFF
			add_step_byte(QMARK, 1'b1);
		end else begin
			seq_held[0] = b;
			seq_have    = 2'd1;
			seq_need    = 3'(len);
			// lead on the last byte of a string: cut off at once
			if (last)
				flush_held_marks();
		end
	endfunction

	// Work out the output transfers caused by one accepted input byte
	function automatic void predict_sanitized(input logic [7:0] b, input logic last);
		clean_byte_t item;
		step_data.delete();
		step_sub.delete();
		if (seq_need != 3'd0 && b[7:6] == 2'b10) begin
			if (int'(seq_have) + 1 >= int'(seq_need)) begin
				// sequence complete: release lead and continuations unchanged
				for (int k = 0; k < int'(seq_have); k++)
					add_step_byte(seq_held[k], 1'b0);
				add_step_byte(b, 1'b0);
				seq_need = 3'd0;
				seq_have = 2'd0;
			end else begin
				seq_held[seq_have] = b;
				seq_have++;
				// string ends mid-sequence
				if (last)
					flush_held_marks();
			end
		end else begin
			// a non-continuation breaks a pending sequence, then counts afresh
			if (seq_need != 3'd0)
				flush_held_marks();
			take_fresh(b, last);
		end
		foreach (step_data[k]) begin
			item.data     = step_data[k];
			item.sub      = step_sub[k];
			item.run_last = (k == step_data.size() - 1);
			item.str_end  = item.run_last && last;
			clean_q.insert(clean_q.size(), item);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Output side: stall generation and checking
	// ------------------------------------------------------------------------

	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_out
		clean_byte_t want;
		clean_byte_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_byte, out_substituted, out_run_last, out_string_end};
			if (clean_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("%0t: unexpected transfer: byte %02h sub %0b run_last %0b end %0b",
						$realtime, got.data, got.sub, got.run_last, got.str_end);
			end else begin
				want = clean_q.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display({"%0t: mismatch: expected byte %02h sub %0b run_last %0b end %0b,",
							" got byte %02h sub %0b run_last %0b end %0b"},
							$realtime, want.data, want.sub, want.run_last, want.str_end,
							got.data, got.sub, got.run_last, got.str_end);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do @(posedge clk); while (in_stall);
		predict_sanitized(b, last);
		@(negedge clk);
	endtask

	// Append a lead (or ASCII for len 1) with random payload and n_cont continuations
	function automatic void push_seq(ref logic [7:0] txt [$], input int len, input int n_cont);
		logic [7:0] r;
		r = 8'($urandom_range(255));
		case (len)
			1:       txt.insert(txt.size(), {1'b0, r[6:0]});
			2:       txt.insert(txt.size(), {3'b110, r[4:0]});
			3:       txt.insert(txt.size(), {4'b1110, r[3:0]});
			default: txt.insert(txt.size(), {5'b11110, r[2:0]});
		endcase
		repeat (n_cont) begin
			r = 8'($urandom_range(255));
			txt.insert(txt.size(), {2'b10, r[5:0]});
		end
	endfunction

	// Random strings: mostly well-formed characters, mixed with broken
	// sequences, stray bytes and strings cut off mid-sequence
	task automatic send_random_text(input int n_bytes);
		logic [7:0] txt [$];
		logic [7:0] b;
		int sent;
		int pick;
		int len;
		sent = 0;
		while (sent < n_bytes) begin
			txt.delete();
			repeat ($urandom_range(1, 10)) begin
				pick = $urandom_range(99);
				len  = $urandom_range(1, 4);
				if (pick < 55) begin
					push_seq(txt, len, len - 1);
				end else if (pick < 70) begin
					// short sequence broken by a non-continuation
					len = $urandom_range(2, 4);
					push_seq(txt, len, $urandom_range(0, len - 2));
					do b = 8'($urandom_range(255)); while (b[7:6] == 2'b10);
					txt.insert(txt.size(), b);
				end else if (pick < 80) begin
					b = 8'($urandom_range(255));
					txt.insert(txt.size(), {2'b10, b[5:0]});
				end else if (pick < 88) begin
					b = 8'($urandom_range(255));
					txt.insert(txt.size(), {5'b11111, b[2:0]});
				end else begin
					b = 8'($urandom_range(255));
					txt.insert(txt.size(), b);
				end
			end
			if ($urandom_range(99) < 20) begin
				len = $urandom_range(2, 4);
				push_seq(txt, len, $urandom_range(0, len - 2));
			end
			foreach (txt[k])
				send_byte(txt[k], k == txt.size() - 1);
			sent += txt.size();
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_ascii_passthrough();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	task automatic test_complete_sequences();
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		// four-byte sequence completing on the last byte of the string
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_invalid_bytes();
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF8, 1'b1);
	endtask

	task automatic test_broken_sequences();
		// three-byte sequence broken by ASCII: two marks, then the letter
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'h41, 1'b1);
		// four-byte sequence broken by a new lead, which then completes
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b1);
	endtask

	task automatic test_cut_off_at_end();
		send_byte(8'hF4, 1'b0);
		send_byte(8'h8F, 1'b1);
		// lone lead as the last byte
		send_byte(8'hDF, 1'b1);
	endtask

	task automatic test_stream_no_idle();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_random_text(65);
	endtask

	task automatic test_stream_sender_gaps();
		send_idle_pct = 59;
		stall_pct     = 0;
		send_random_text(65);
	endtask

	task automatic test_stream_receiver_stalls();
		send_idle_pct = 0;
		stall_pct     = 59;
		send_random_text(65);
	endtask

	task automatic test_stream_both_idle();
		send_idle_pct = 37;
		stall_pct     = 37;
		send_random_text(65);
	endtask

	// Output held off long enough that the block fills and stalls its input
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 150;
		send_random_text(30);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_ascii_passthrough();
		test_complete_sequences();
		test_invalid_bytes();
		test_broken_sequences();
		test_cut_off_at_end();
		test_stream_no_idle();
		test_stream_sender_gaps();
		test_stream_receiver_stalls();
		test_stream_both_idle();
		test_output_backpressure();

		in_valid <= 1'b0;
		while (clean_q.size() != 0)
			@(posedge clk);
		// catch any stray transfer after the last expected one
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_cnt == 0 && clean_q.size() == 0)
			$display("tb_utf8_byte_sanitizer_unit: PASS");
		else
			$display("tb_utf8_byte_sanitizer_unit: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/usbs_pkg.sv
hw/rtl/usbs_decode.sv
hw/rtl/usbs_out_buf.sv
hw/rtl/utf8_byte_sanitizer_unit.sv
sim/tb_utf8_byte_sanitizer_unit.sv
